// ----- rtl/core/esdt_pkg.sv -----
package esdt_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned YearXW = 13;
  localparam int unsigned DoyW   = 9;

  localparam logic [YearW-1:0] BaseYearReset = 12'd1980;
  localparam logic [YearXW-1:0] LastYear     = 13'd2099;

  // Floor division by a constant is a multiply by a rounded-up reciprocal and a shift.
  // Each shift is the dividend width plus the divisor's bit length, which keeps the
  // quotient exact over the whole dividend range.
  localparam int unsigned DayShift  = 35;  // (s >> 7) / 675, dividend below 2^25
  localparam int unsigned CycShift  = 27;  // days / 1461, dividend below 2^16
  localparam int unsigned HourShift = 21;  // (tod >> 4) / 225, dividend below 2^13
  localparam int unsigned MinShift  = 14;  // (rem >> 2) / 15, dividend below 2^10

  localparam logic [25:0] DayRecip  = 26'(((64'd1 << DayShift) + 64'd674) / 64'd675);
  localparam logic [16:0] CycRecip  = 17'(((64'd1 << CycShift) + 64'd1460) / 64'd1461);
  localparam logic [13:0] HourRecip = 14'(((64'd1 << HourShift) + 64'd224) / 64'd225);
  localparam logic [10:0] MinRecip  = 11'(((64'd1 << MinShift) + 64'd14) / 64'd15);

  localparam logic [31:0] SecsPerDay   = 32'd86400;
  localparam logic [16:0] SecsPerHour  = 17'd3600;
  localparam logic [11:0] SecsPerMin   = 12'd60;
  localparam logic [15:0] DaysPerCycle = 16'd1461;

  // Day-of-year boundaries inside the four-year cycle.
  localparam logic [10:0] CycYear1 = 11'd366;
  localparam logic [10:0] CycYear2 = 11'd731;
  localparam logic [10:0] CycYear3 = 11'd1096;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic       bad;
  } esdt_date_t;

  // First day of a month, counted from 1 January, in a common year.
  function automatic logic [DoyW-1:0] month_start(input logic [3:0] m);
    logic [DoyW-1:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/esdt_month_walk.sv -----
module esdt_month_walk
  import esdt_pkg::*;
(
  input  logic [YearXW-1:0] year,
  input  logic [DoyW-1:0]   doy,
  output esdt_date_t        date
);

  logic            century;
  logic            quad;
  logic            leap;
  logic [DoyW-1:0] start;
  logic [DoyW-1:0] first;
  logic [DoyW-1:0] year_len;
  logic [3:0]      midx;
  logic [DoyW-1:0] dom;

  // Only years up to the last supported one matter, so the centuries are matched directly.
  always_comb begin
    century = 1'b0;
    quad    = 1'b0;
    for (int i = 0; i <= 20; i++) begin
      if (year == 13'(i * 100)) begin
        century = 1'b1;
        if ((i & 3) == 0) quad = 1'b1;
      end
    end
    leap = (year[1:0] == 2'b00) && (!century || quad);
  end

  always_comb begin
    midx  = 4'd0;
    first = '0;
    for (int m = 1; m < 12; m++) begin
      start = month_start(4'(m));
      if (m >= 2) start = start + 9'(leap);
      if (doy >= start) begin
        midx  = 4'(m);
        first = start;
      end
    end
    start    = '0;
    year_len = 9'd365 + 9'(leap);
    dom      = doy - first + 9'd1;
    date.bad = (year > LastYear) || (doy >= year_len);
    if (date.bad) begin
      date.month = '0;
      date.day   = '0;
    end else begin
      date.month = midx + 4'd1;
      date.day   = dom[4:0];
    end
  end

endmodule

// ----- rtl/core/epoch_seconds_to_date_time_top.sv -----
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_seconds_count[31:0]
// out      output     out_valid / out_ready  year, month, day, hour, minute, second,
//                                            out_of_range
// cfg      input      cfg_valid / cfg_ready  cfg_base_year[11:0]
//
// One count is taken per cycle while in_ready is high; the pipeline has one stage each for the
// chain of four reciprocal multiplications (days, cycles, hours, minutes), the split of the
// cycle into its years and the month walk, with the subtractions beside them.
// Reset clears the stage valid bits and sets the base year to 1980.
// Each stage holds while the stage after it is full and stalled, so empty stages still fill.
module epoch_seconds_to_date_time_top
  import esdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_seconds_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic             out_out_of_range,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [YearW-1:0] cfg_base_year
);

  localparam int unsigned Stages = 6;

  logic [YearW-1:0]  base_year_r;
  logic [Stages-1:0] v_r;
  logic [Stages-1:0] en;

  // Stage 1
  logic [50:0] day_prod;
  logic [15:0] s1_days_r;
  logic [31:0] s1_secs_r;
  // Stage 2
  logic [31:0] day_secs;
  logic [32:0] cyc_prod;
  logic [16:0] s2_tod_r;
  logic [15:0] s2_days_r;
  logic [5:0]  s2_cyc_r;
  // Stage 3
  logic [15:0] dc_full;
  logic [25:0] hour_prod;
  logic [10:0] s3_dc_r;
  logic [5:0]  s3_cyc_r;
  logic [4:0]  s3_hour_r;
  logic [16:0] s3_tod_r;
  // Stage 4
  logic [16:0]       hour_secs;
  logic [11:0]       rem_nxt;
  logic [1:0]        k_nxt;
  logic [10:0]       doy_nxt;
  logic [YearXW-1:0] year_nxt;
  logic [YearXW-1:0] s4_year_r;
  logic [DoyW-1:0]   s4_doy_r;
  logic [4:0]        s4_hour_r;
  logic [11:0]       s4_rem_r;
  // Stage 5
  logic [19:0]       min_prod;
  logic [YearXW-1:0] s5_year_r;
  logic [DoyW-1:0]   s5_doy_r;
  logic [4:0]        s5_hour_r;
  logic [5:0]        s5_min_r;
  logic [11:0]       s5_rem_r;
  // Stage 6
  logic [11:0] sec_nxt;
  esdt_date_t  date;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_year_r <= BaseYearReset;
    end else if (cfg_valid && cfg_ready) begin
      base_year_r <= cfg_base_year;
    end
  end

  // A stage may load when it is empty or its content moves on in the same cycle.
  always_comb begin
    en[Stages-1] = !v_r[Stages-1] || out_ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[Stages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < Stages; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign day_prod = 51'(in_seconds_count[31:7]) * 51'(DayRecip);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_days_r <= day_prod[50:35];
      s1_secs_r <= in_seconds_count;
    end
  end

  assign day_secs = 32'(s1_days_r) * SecsPerDay;
  assign cyc_prod = 33'(s1_days_r) * 33'(CycRecip);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_tod_r  <= 17'(s1_secs_r - day_secs);
      s2_days_r <= s1_days_r;
      s2_cyc_r  <= cyc_prod[32:27];
    end
  end

  assign dc_full   = s2_days_r - 16'(s2_cyc_r) * DaysPerCycle;
  assign hour_prod = 26'(s2_tod_r[16:4]) * 26'(HourRecip);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_dc_r   <= dc_full[10:0];
      s3_cyc_r  <= s2_cyc_r;
      s3_hour_r <= hour_prod[25:21];
      s3_tod_r  <= s2_tod_r;
    end
  end

  assign hour_secs = 17'(s3_hour_r) * SecsPerHour;
  assign rem_nxt   = 12'(s3_tod_r - hour_secs);

  // The first year of each cycle is the long one.
  always_comb begin
    priority if (s3_dc_r >= CycYear3) begin
      k_nxt   = 2'd3;
      doy_nxt = s3_dc_r - CycYear3;
    end else if (s3_dc_r >= CycYear2) begin
      k_nxt   = 2'd2;
      doy_nxt = s3_dc_r - CycYear2;
    end else if (s3_dc_r >= CycYear1) begin
      k_nxt   = 2'd1;
      doy_nxt = s3_dc_r - CycYear1;
    end else begin
      k_nxt   = 2'd0;
      doy_nxt = s3_dc_r;
    end
    year_nxt = 13'(base_year_r) + 13'({s3_cyc_r, 2'b00}) + 13'(k_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_year_r <= year_nxt;
      s4_doy_r  <= doy_nxt[DoyW-1:0];
      s4_hour_r <= s3_hour_r;
      s4_rem_r  <= rem_nxt;
    end
  end

  assign min_prod = 20'(s4_rem_r[11:2]) * 20'(MinRecip);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_year_r <= s4_year_r;
      s5_doy_r  <= s4_doy_r;
      s5_hour_r <= s4_hour_r;
      s5_min_r  <= min_prod[19:14];
      s5_rem_r  <= s4_rem_r;
    end
  end

  assign sec_nxt = s5_rem_r - 12'(s5_min_r) * SecsPerMin;

  esdt_month_walk u_month_walk (
    .year (s5_year_r),
    .doy  (s5_doy_r),
    .date (date)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_out_of_range <= date.bad;
      out_month        <= date.month;
      out_day          <= date.day;
      if (date.bad) begin
        out_year   <= '0;
        out_hour   <= '0;
        out_minute <= '0;
        out_second <= '0;
      end else begin
        out_year   <= s5_year_r[YearW-1:0];
        out_hour   <= s5_hour_r;
        out_minute <= s5_min_r;
        out_second <= sec_nxt[5:0];
      end
    end
  end

endmodule
